@@ design/tnt_pkg.sv @@
// ----------------------------------------------------------------------------
// tnt_pkg
// Shared widths, state codes and controller/datapath command types for the
// triangle normal and tangent unit.
// ----------------------------------------------------------------------------
package tnt_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int COORD_FRAC       = 16;
    localparam int NORMAL_OUT_WIDTH = 16;
    localparam int NORM_BITS        = 30;

    localparam int EDGE_W   = COORD_WIDTH + 1;
    localparam int MUL_W    = (EDGE_W > NORM_BITS + 1) ? EDGE_W : NORM_BITS + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int DEN_W    = 2 * COORD_WIDTH + 2;
    localparam int NUM_A    = 2 * COORD_WIDTH + 19;
    localparam int NUM_B    = NORM_BITS + NORMAL_FRAC_BITS + 2;
    localparam int NUM_W    = (NUM_A > NUM_B) ? NUM_A : NUM_B;
    localparam int SQ_W     = 64;
    localparam int LEN_W    = 32;
    localparam int SQ_STEPS = 32;
    localparam int CNT_W    = $clog2(NUM_W + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_EDGE, S_XMUL, S_XACC, S_CHK, S_NORM, S_SQMUL, S_SQACC, S_SQRT,
        S_NDIV, S_NRUN, S_NWR, S_TAN, S_TMUL, S_TACC, S_TDIV, S_TRUN, S_TWR, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        M_E1Y_E2Z, M_E1Z_E2Y, M_E1Z_E2X, M_E1X_E2Z, M_E1X_E2Y, M_E1Y_E2X,
        M_DU1_DV2, M_DU2_DV1, M_SQ, M_DV2_E1, M_DV1_E2
    } t_msel;

    typedef enum logic [1:0] {A_HOLD, A_LOAD, A_ADD, A_SUB} t_acc;

    typedef enum logic [2:0] {
        ST_NONE, ST_CR0, ST_CR1, ST_CR2, ST_DET, ST_SUM, ST_NUM
    } t_store;

    typedef enum logic {DS_NORMAL, DS_TANGENT} t_div_src;

    typedef struct packed {
        logic     cap_en;
        logic [1:0] cap_slot;
        logic     edge_en;
        logic     mul_en;
        t_msel    msel;
        logic [1:0] k;
        t_acc     acc;
        t_store   store;
        logic     area_set;
        logic     norm_init;
        logic     norm_shr;
        logic     norm_shl;
        logic     sqrt_step;
        logic     div_init;
        t_div_src div_src;
        logic     div_step;
        logic     nrm_wr;
        logic     uv_set;
        logic     tan_wr;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic cr_zero;
        logic det_zero;
        logic m_hi;
        logic m_top;
    } t_stat;

endpackage

@@ design/tnt_vtx_if.sv @@
// ----------------------------------------------------------------------------
// tnt_vtx_if
// Vertex request channel: position and texture coordinate, valid/ready.
// ----------------------------------------------------------------------------
interface tnt_vtx_if import tnt_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] tex_u;
    logic signed [COORD_WIDTH-1:0] tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

@@ design/tnt_res_if.sv @@
// ----------------------------------------------------------------------------
// tnt_res_if
// Result request channel: face normal, tangent and degeneracy flags.
// ----------------------------------------------------------------------------
interface tnt_res_if import tnt_pkg::*; ();
    logic                               valid;
    logic                               ready;
    logic signed [NORMAL_OUT_WIDTH-1:0] normal_x;
    logic signed [NORMAL_OUT_WIDTH-1:0] normal_y;
    logic signed [NORMAL_OUT_WIDTH-1:0] normal_z;
    logic signed [COORD_WIDTH-1:0]      tangent_x;
    logic signed [COORD_WIDTH-1:0]      tangent_y;
    logic signed [COORD_WIDTH-1:0]      tangent_z;
    logic                               uv_degenerate;
    logic                               area_degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, tangent_x, tangent_y,
                    tangent_z, uv_degenerate, area_degenerate, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, tangent_x, tangent_y,
                    tangent_z, uv_degenerate, area_degenerate, output ready);
endinterface

@@ design/triangle_normal_tangent.sv @@
// ----------------------------------------------------------------------------
// triangle_normal_tangent
// Unit face normal and tangent of unindexed triangles in fixed point.
//
//   channel  | dir | request
//   i_vtx    | in  | one vertex: pos_x/y/z, tex_u/v (Q16.16)
//   o_res    | out | normal (Q1.14), tangent (Q16.16), degeneracy flags
//   i_cfg_*  | in  | make_normals write, always ready
//
// Vertices one and two of a triangle are only stored. The third starts the
// work: 17 shared-multiplier products, a normalising shift, a 32-step square
// root and six 83-step restoring divides.
// Vertex requests are held off during that work; a finished result waits in
// the output register while the next triangle's vertices come in.
// Reset is synchronous, active low; make_normals resets to 1.
// ----------------------------------------------------------------------------
module triangle_normal_tangent import tnt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tnt_vtx_if.sink   i_vtx,
    tnt_res_if.source o_res,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_make_normals
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    tnt_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_vtx_valid        (i_vtx.valid),
        .o_vtx_ready        (i_vtx.ready),
        .o_res_valid        (o_res.valid),
        .i_res_ready        (o_res.ready),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_make_normals (i_cfg_make_normals),
        .i_stat             (stat),
        .o_cmd              (cmd)
    );

    tnt_dp u_dp (
        .i_clk             (i_clk),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_pos_x           (i_vtx.pos_x),
        .i_pos_y           (i_vtx.pos_y),
        .i_pos_z           (i_vtx.pos_z),
        .i_tex_u           (i_vtx.tex_u),
        .i_tex_v           (i_vtx.tex_v),
        .o_normal_x        (o_res.normal_x),
        .o_normal_y        (o_res.normal_y),
        .o_normal_z        (o_res.normal_z),
        .o_tangent_x       (o_res.tangent_x),
        .o_tangent_y       (o_res.tangent_y),
        .o_tangent_z       (o_res.tangent_z),
        .o_uv_degenerate   (o_res.uv_degenerate),
        .o_area_degenerate (o_res.area_degenerate)
    );

endmodule

@@ design/tnt_dp.sv @@
// ----------------------------------------------------------------------------
// tnt_dp
// Datapath: vertex store, shared multiplier and accumulator, normalising
// shifter, bit-serial square root and restoring divider, result registers.
// ----------------------------------------------------------------------------
module tnt_dp import tnt_pkg::*; (
    input  logic                               i_clk,
    input  t_cmd                               i_cmd,
    output t_stat                              o_stat,
    input  logic signed [COORD_WIDTH-1:0]      i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]      i_pos_y,
    input  logic signed [COORD_WIDTH-1:0]      i_pos_z,
    input  logic signed [COORD_WIDTH-1:0]      i_tex_u,
    input  logic signed [COORD_WIDTH-1:0]      i_tex_v,
    output logic signed [NORMAL_OUT_WIDTH-1:0] o_normal_x,
    output logic signed [NORMAL_OUT_WIDTH-1:0] o_normal_y,
    output logic signed [NORMAL_OUT_WIDTH-1:0] o_normal_z,
    output logic signed [COORD_WIDTH-1:0]      o_tangent_x,
    output logic signed [COORD_WIDTH-1:0]      o_tangent_y,
    output logic signed [COORD_WIDTH-1:0]      o_tangent_z,
    output logic                               o_uv_degenerate,
    output logic                               o_area_degenerate
);

    localparam logic [NUM_W-1:0] LIM_POS = NUM_W'({(COORD_WIDTH-1){1'b1}});
    localparam logic [NUM_W-1:0] LIM_NEG = NUM_W'({1'b1, {(COORD_WIDTH-1){1'b0}}});

    logic signed [COORD_WIDTH-1:0] r_pos [3][3];
    logic signed [COORD_WIDTH-1:0] r_tex [3][2];
    logic signed [EDGE_W-1:0]      r_e1 [3];
    logic signed [EDGE_W-1:0]      r_e2 [3];
    logic signed [EDGE_W-1:0]      r_du1, r_dv1, r_du2, r_dv2;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc, n_acc;
    logic signed [ACC_W-1:0]       r_cr [3];
    logic signed [ACC_W-1:0]       r_det;
    logic signed [ACC_W-1:0]       r_num;
    logic        [ACC_W-1:0]       r_m [3];
    logic        [SQ_W-1:0]        r_s, r_res, r_bit;
    logic        [NUM_W-1:0]       r_dnum, r_q;
    logic        [DEN_W-1:0]       r_den, r_rem;
    logic                          r_neg;
    logic signed [NORMAL_OUT_WIDTH-1:0] r_nrm [3];
    logic signed [COORD_WIDTH-1:0]      r_tan [3];
    logic                          r_uv, r_area;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic        [ACC_W-1:0] m_or, abs_num, abs_det;
    logic        [SQ_W-1:0]  sq_try;
    logic        [DEN_W:0]   rem_sh;
    logic        [NUM_W-1:0] mag;
    logic        [COORD_WIDTH-1:0]      tan_v;
    logic        [NORMAL_OUT_WIDTH-1:0] nrm_v;

    always_comb begin
        unique case (i_cmd.msel)
            M_E1Y_E2Z: begin mul_a = MUL_W'(r_e1[1]); mul_b = MUL_W'(r_e2[2]); end
            M_E1Z_E2Y: begin mul_a = MUL_W'(r_e1[2]); mul_b = MUL_W'(r_e2[1]); end
            M_E1Z_E2X: begin mul_a = MUL_W'(r_e1[2]); mul_b = MUL_W'(r_e2[0]); end
            M_E1X_E2Z: begin mul_a = MUL_W'(r_e1[0]); mul_b = MUL_W'(r_e2[2]); end
            M_E1X_E2Y: begin mul_a = MUL_W'(r_e1[0]); mul_b = MUL_W'(r_e2[1]); end
            M_E1Y_E2X: begin mul_a = MUL_W'(r_e1[1]); mul_b = MUL_W'(r_e2[0]); end
            M_DU1_DV2: begin mul_a = MUL_W'(r_du1);   mul_b = MUL_W'(r_dv2);   end
            M_DU2_DV1: begin mul_a = MUL_W'(r_du2);   mul_b = MUL_W'(r_dv1);   end
            M_SQ: begin
                mul_a = signed'(MUL_W'(r_m[i_cmd.k][NORM_BITS-1:0]));
                mul_b = mul_a;
            end
            M_DV2_E1:  begin mul_a = MUL_W'(r_dv2);   mul_b = MUL_W'(r_e1[i_cmd.k]); end
            M_DV1_E2:  begin mul_a = MUL_W'(r_dv1);   mul_b = MUL_W'(r_e2[i_cmd.k]); end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        unique case (i_cmd.acc)
            A_LOAD:  n_acc = ACC_W'(r_prod);
            A_ADD:   n_acc = r_acc + ACC_W'(r_prod);
            A_SUB:   n_acc = r_acc - ACC_W'(r_prod);
            default: n_acc = r_acc;
        endcase
    end

    assign m_or    = r_m[0] | r_m[1] | r_m[2];
    assign abs_num = r_num[ACC_W-1] ? ACC_W'(-r_num) : ACC_W'(r_num);
    assign abs_det = r_det[ACC_W-1] ? ACC_W'(-r_det) : ACC_W'(r_det);
    assign sq_try  = r_res + r_bit;
    assign rem_sh  = {r_rem, r_dnum[NUM_W-1]};

    always_comb begin
        if (r_neg) begin
            mag = (r_q > LIM_NEG) ? LIM_NEG : r_q;
        end else begin
            mag = (r_q > LIM_POS) ? LIM_POS : r_q;
        end
        tan_v = r_neg ? -mag[COORD_WIDTH-1:0] : mag[COORD_WIDTH-1:0];
        nrm_v = r_neg ? -r_q[NORMAL_OUT_WIDTH-1:0] : r_q[NORMAL_OUT_WIDTH-1:0];
    end

    assign o_stat.cr_zero  = (r_cr[0] == '0) && (r_cr[1] == '0) && (r_cr[2] == '0);
    assign o_stat.det_zero = (r_det == '0);
    assign o_stat.m_hi     = |m_or[ACC_W-1:NORM_BITS];
    assign o_stat.m_top    = m_or[NORM_BITS-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            r_pos[i_cmd.cap_slot][0] <= i_pos_x;
            r_pos[i_cmd.cap_slot][1] <= i_pos_y;
            r_pos[i_cmd.cap_slot][2] <= i_pos_z;
            r_tex[i_cmd.cap_slot][0] <= i_tex_u;
            r_tex[i_cmd.cap_slot][1] <= i_tex_v;
        end
        if (i_cmd.edge_en) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k]  <= EDGE_W'(r_pos[1][k]) - EDGE_W'(r_pos[0][k]);
                r_e2[k]  <= EDGE_W'(r_pos[2][k]) - EDGE_W'(r_pos[0][k]);
                r_nrm[k] <= '0;
                r_tan[k] <= '0;
            end
            r_du1  <= EDGE_W'(r_tex[1][0]) - EDGE_W'(r_tex[0][0]);
            r_dv1  <= EDGE_W'(r_tex[1][1]) - EDGE_W'(r_tex[0][1]);
            r_du2  <= EDGE_W'(r_tex[2][0]) - EDGE_W'(r_tex[0][0]);
            r_dv2  <= EDGE_W'(r_tex[2][1]) - EDGE_W'(r_tex[0][1]);
            r_uv   <= 1'b0;
            r_area <= 1'b0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        r_acc <= n_acc;
        unique case (i_cmd.store)
            ST_CR0: r_cr[0] <= n_acc;
            ST_CR1: r_cr[1] <= n_acc;
            ST_CR2: r_cr[2] <= n_acc;
            ST_DET: r_det   <= n_acc;
            ST_NUM: r_num   <= n_acc;
            ST_SUM: begin
                r_s   <= SQ_W'(n_acc);
                r_res <= '0;
                r_bit <= SQ_W'(1) << 62;
            end
            default: ;
        endcase
        if (i_cmd.area_set) r_area <= 1'b1;
        if (i_cmd.uv_set)   r_uv   <= 1'b1;
        if (i_cmd.norm_init) begin
            for (int k = 0; k < 3; k++) begin
                r_m[k] <= r_cr[k][ACC_W-1] ? ACC_W'(-r_cr[k]) : ACC_W'(r_cr[k]);
            end
        end else if (i_cmd.norm_shr) begin
            for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] >> 1;
        end else if (i_cmd.norm_shl) begin
            for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] << 1;
        end
        if (i_cmd.sqrt_step) begin
            if (r_s >= sq_try) begin
                r_s   <= r_s - sq_try;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_q   <= '0;
            if (i_cmd.div_src == DS_NORMAL) begin
                r_dnum <= (NUM_W'(r_m[i_cmd.k][NORM_BITS-1:0]) << NORMAL_FRAC_BITS)
                        + NUM_W'(r_res[LEN_W-1:1]);
                r_den  <= DEN_W'(r_res[LEN_W-1:0]);
                r_neg  <= r_cr[i_cmd.k][ACC_W-1];
            end else begin
                r_dnum <= (NUM_W'(abs_num) << COORD_FRAC) + NUM_W'(abs_det >> 1);
                r_den  <= DEN_W'(abs_det);
                r_neg  <= r_num[ACC_W-1] ^ r_det[ACC_W-1];
            end
        end else if (i_cmd.div_step) begin
            r_dnum <= r_dnum << 1;
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem <= DEN_W'(rem_sh - {1'b0, r_den});
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.nrm_wr) r_nrm[i_cmd.k] <= signed'(nrm_v);
        if (i_cmd.tan_wr) r_tan[i_cmd.k] <= signed'(tan_v);
        if (i_cmd.out_load) begin
            o_normal_x        <= r_nrm[0];
            o_normal_y        <= r_nrm[1];
            o_normal_z        <= r_nrm[2];
            o_tangent_x       <= r_tan[0];
            o_tangent_y       <= r_tan[1];
            o_tangent_z       <= r_tan[2];
            o_uv_degenerate   <= r_uv;
            o_area_degenerate <= r_area;
        end
    end

endmodule

@@ design/tnt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tnt_ctrl
// Controller: corner counting, normals enable register, sequencing of the
// datapath and the result request valid.
// ----------------------------------------------------------------------------
module tnt_ctrl import tnt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_vtx_valid,
    output logic  o_vtx_ready,
    output logic  o_res_valid,
    input  logic  i_res_ready,
    input  logic  i_cfg_valid,
    input  logic  i_cfg_make_normals,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state           r_state, n_state;
    logic [1:0]       r_corner;
    logic [2:0]       r_x;
    logic [1:0]       r_k;
    logic             r_ph;
    logic [CNT_W-1:0] r_cnt;
    logic             r_make;
    logic             r_out_valid;
    logic             vtx_acc, out_free;

    assign vtx_acc     = i_vtx_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_res_ready;
    assign o_vtx_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (vtx_acc && r_corner == 2'd2) n_state = S_EDGE;
            S_EDGE:  n_state = S_XMUL;
            S_XMUL:  n_state = S_XACC;
            S_XACC:  n_state = (r_x == 3'd7) ? S_CHK : S_XMUL;
            S_CHK: begin
                priority if (!r_make || i_stat.cr_zero) n_state = S_TAN;
                else n_state = S_NORM;
            end
            S_NORM:  if (!i_stat.m_hi && i_stat.m_top) n_state = S_SQMUL;
            S_SQMUL: n_state = S_SQACC;
            S_SQACC: n_state = (r_k == 2'd2) ? S_SQRT : S_SQMUL;
            S_SQRT:  if (r_cnt == CNT_W'(SQ_STEPS - 1)) n_state = S_NDIV;
            S_NDIV:  n_state = S_NRUN;
            S_NRUN:  if (r_cnt == CNT_W'(NUM_W - 1)) n_state = S_NWR;
            S_NWR:   n_state = (r_k == 2'd2) ? S_TAN : S_NDIV;
            S_TAN:   n_state = i_stat.det_zero ? S_DONE : S_TMUL;
            S_TMUL:  n_state = S_TACC;
            S_TACC:  n_state = r_ph ? S_TDIV : S_TMUL;
            S_TDIV:  n_state = S_TRUN;
            S_TRUN:  if (r_cnt == CNT_W'(NUM_W - 1)) n_state = S_TWR;
            S_TWR:   n_state = (r_k == 2'd2) ? S_DONE : S_TMUL;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.msel     = M_E1Y_E2Z;
        o_cmd.acc      = A_HOLD;
        o_cmd.store    = ST_NONE;
        o_cmd.div_src  = DS_NORMAL;
        o_cmd.k        = r_k;
        o_cmd.cap_slot = r_corner;
        unique case (r_state)
            S_IDLE:  o_cmd.cap_en = vtx_acc;
            S_EDGE:  o_cmd.edge_en = 1'b1;
            S_XMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = t_msel'({1'b0, r_x});
            end
            S_XACC: begin
                o_cmd.acc = r_x[0] ? A_SUB : A_LOAD;
                if (r_x[0]) begin
                    unique case (r_x[2:1])
                        2'd0: o_cmd.store = ST_CR0;
                        2'd1: o_cmd.store = ST_CR1;
                        2'd2: o_cmd.store = ST_CR2;
                        default: o_cmd.store = ST_DET;
                    endcase
                end
            end
            S_CHK: begin
                o_cmd.area_set  = r_make && i_stat.cr_zero;
                o_cmd.norm_init = r_make && !i_stat.cr_zero;
            end
            S_NORM: begin
                o_cmd.norm_shr = i_stat.m_hi;
                o_cmd.norm_shl = !i_stat.m_hi && !i_stat.m_top;
            end
            S_SQMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = M_SQ;
            end
            S_SQACC: begin
                o_cmd.acc   = (r_k == 2'd0) ? A_LOAD : A_ADD;
                o_cmd.store = (r_k == 2'd2) ? ST_SUM : ST_NONE;
            end
            S_SQRT:  o_cmd.sqrt_step = 1'b1;
            S_NDIV:  o_cmd.div_init = 1'b1;
            S_NRUN:  o_cmd.div_step = 1'b1;
            S_NWR:   o_cmd.nrm_wr = 1'b1;
            S_TAN:   o_cmd.uv_set = i_stat.det_zero;
            S_TMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = r_ph ? M_DV1_E2 : M_DV2_E1;
            end
            S_TACC: begin
                o_cmd.acc   = r_ph ? A_SUB : A_LOAD;
                o_cmd.store = r_ph ? ST_NUM : ST_NONE;
            end
            S_TDIV: begin
                o_cmd.div_init = 1'b1;
                o_cmd.div_src  = DS_TANGENT;
            end
            S_TRUN:  o_cmd.div_step = 1'b1;
            S_TWR:   o_cmd.tan_wr = 1'b1;
            S_DONE:  o_cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_corner    <= '0;
            r_x         <= '0;
            r_k         <= '0;
            r_ph        <= 1'b0;
            r_cnt       <= '0;
            r_make      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_make <= i_cfg_make_normals;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (vtx_acc) r_corner <= (r_corner == 2'd2) ? 2'd0 : r_corner + 2'd1;
                    r_x <= '0;
                end
                S_XACC: r_x <= r_x + 3'd1;
                S_CHK:  r_k <= '0;
                S_SQACC: begin
                    r_k   <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    r_cnt <= '0;
                end
                S_SQRT: r_cnt <= r_cnt + CNT_W'(1);
                S_NDIV: r_cnt <= '0;
                S_NRUN: r_cnt <= r_cnt + CNT_W'(1);
                S_NWR:  r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                S_TAN: begin
                    r_k  <= '0;
                    r_ph <= 1'b0;
                end
                S_TACC: r_ph <= !r_ph;
                S_TDIV: r_cnt <= '0;
                S_TRUN: r_cnt <= r_cnt + CNT_W'(1);
                S_TWR:  r_k <= r_k + 2'd1;
                default: ;
            endcase
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triangle normal and tangent unit. Streams
// directed and random triangles with random idling on both channels,
// predicts each face result in fixed point and checks it field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import tnt_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [NORMAL_OUT_WIDTH-1:0] nx, ny, nz;
        logic signed [COORD_WIDTH-1:0]      tx, ty, tz;
        logic                               uv_deg, area_deg;
    } face_t;

    localparam int WATCHDOG = 20000;
    localparam int SETTLE   = 800;

    class face_scoreboard;
        logic signed [COORD_WIDTH-1:0] pos_hold[6];
        logic signed [COORD_WIDTH-1:0] uv_hold[4];
        int    corners;
        bit    make_normals;
        face_t faces_due[$];
        int    errors;

        function new();
            foreach (pos_hold[k]) pos_hold[k] = '0;
            foreach (uv_hold[k]) uv_hold[k] = '0;
            corners = 0;
            make_normals = 1;
            errors = 0;
        endfunction

        function automatic wide_t mag(wide_t v);
            return (v < 0) ? -v : v;
        endfunction

        function automatic int bit_len(wide_t v);
            int n;
            n = 0;
            for (int b = 0; b < 128; b++) if (v[b]) n = b + 1;
            return n;
        endfunction

        function automatic logic [63:0] root_floor(logic [63:0] s);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > s) b = b >> 2;
            while (b != 0) begin
                if (s >= r + b) begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_vertex(logic signed [COORD_WIDTH-1:0] p[3],
                                  logic signed [COORD_WIDTH-1:0] u,
                                  logic signed [COORD_WIDTH-1:0] v);
            wide_t e1[3], e2[3], cr[3], m[3], du1, dv1, du2, dv2, det, num, ad, q, lim;
            logic [63:0] s, len, n;
            int bl;
            face_t f;
            if (corners < 2) begin
                for (int k = 0; k < 3; k++) pos_hold[3*corners+k] = p[k];
                uv_hold[2*corners] = u;
                uv_hold[2*corners+1] = v;
                corners++;
                return;
            end
            corners = 0;
            for (int k = 0; k < 3; k++) begin
                e1[k] = wide_t'(pos_hold[3+k]) - wide_t'(pos_hold[k]);
                e2[k] = wide_t'(p[k]) - wide_t'(pos_hold[k]);
            end
            du1 = wide_t'(uv_hold[2]) - wide_t'(uv_hold[0]);
            dv1 = wide_t'(uv_hold[3]) - wide_t'(uv_hold[1]);
            du2 = wide_t'(u) - wide_t'(uv_hold[0]);
            dv2 = wide_t'(v) - wide_t'(uv_hold[1]);
            f.nx = 0; f.ny = 0; f.nz = 0;
            f.area_deg = 0;
            if (make_normals) begin
                cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
                cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
                cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
                bl = 0;
                for (int k = 0; k < 3; k++) begin
                    m[k] = mag(cr[k]);
                    if (bit_len(m[k]) > bl) bl = bit_len(m[k]);
                end
                if (bl == 0) begin
                    f.area_deg = 1;
                end else begin
                    s = 0;
                    for (int k = 0; k < 3; k++) begin
                        m[k] = (bl > NORM_BITS) ? (m[k] >> (bl - NORM_BITS))
                                                : (m[k] << (NORM_BITS - bl));
                        s = s + m[k][63:0] * m[k][63:0];
                    end
                    len = root_floor(s);
                    for (int k = 0; k < 3; k++) begin
                        n = ((m[k][63:0] << NORMAL_FRAC_BITS) + len / 2) / len;
                        if (cr[k] < 0) n = -n;
                        if (k == 0) f.nx = n[15:0];
                        else if (k == 1) f.ny = n[15:0];
                        else f.nz = n[15:0];
                    end
                end
            end
            det = du1*dv2 - du2*dv1;
            f.uv_deg = (det == 0);
            f.tx = 0; f.ty = 0; f.tz = 0;
            if (!f.uv_deg) begin
                ad = mag(det);
                for (int k = 0; k < 3; k++) begin
                    num = dv2*e1[k] - dv1*e2[k];
                    q = ((mag(num) << COORD_FRAC) + (ad >>> 1)) / ad;
                    lim = (num < 0) != (det < 0) ? (wide_t'(1) <<< 31)
                                                  : (wide_t'(1) <<< 31) - 1;
                    if (q > lim) q = lim;
                    if ((num < 0) != (det < 0)) q = -q;
                    if (k == 0) f.tx = q[31:0];
                    else if (k == 1) f.ty = q[31:0];
                    else f.tz = q[31:0];
                end
            end
            faces_due = {faces_due, f};
        endfunction

        function void check_face(face_t got);
            face_t want;
            if (faces_due.size() == 0) begin
                $display("%0t: unexpected result nx=%0d tx=%0d", $time, got.nx, got.tx);
                errors++;
                return;
            end
            want = faces_due.pop_front();
            if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz) begin
                $display("%0t: normal exp %0d %0d %0d got %0d %0d %0d", $time,
                         want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
                errors++;
            end
            if (got.tx !== want.tx || got.ty !== want.ty || got.tz !== want.tz) begin
                $display("%0t: tangent exp %0d %0d %0d got %0d %0d %0d", $time,
                         want.tx, want.ty, want.tz, got.tx, got.ty, got.tz);
                errors++;
            end
            if (got.uv_deg !== want.uv_deg || got.area_deg !== want.area_deg) begin
                $display("%0t: flags exp uv=%0b area=%0b got uv=%0b area=%0b", $time,
                         want.uv_deg, want.area_deg, got.uv_deg, got.area_deg);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_valid = 0;
    logic i_cfg_make_normals = 0;
    logic o_cfg_ready;
    bit   steady = 0;
    int   idle_cycles = 0;

    tnt_vtx_if vtx();
    tnt_res_if res();
    face_scoreboard faces = new();

    triangle_normal_tangent i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vtx(vtx), .o_res(res),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_make_normals(i_cfg_make_normals)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        vtx.valid = 0;
        vtx.pos_x = 0; vtx.pos_y = 0; vtx.pos_z = 0;
        vtx.tex_u = 0; vtx.tex_v = 0;
        res.ready = 0;
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        face_t got;
        if (i_rst_n && vtx.valid && vtx.ready) begin
            logic signed [COORD_WIDTH-1:0] p[3];
            p[0] = vtx.pos_x; p[1] = vtx.pos_y; p[2] = vtx.pos_z;
            faces.note_vertex(p, vtx.tex_u, vtx.tex_v);
        end
        if (i_rst_n && res.valid && res.ready) begin
            got.nx = res.normal_x; got.ny = res.normal_y; got.nz = res.normal_z;
            got.tx = res.tangent_x; got.ty = res.tangent_y; got.tz = res.tangent_z;
            got.uv_deg = res.uv_degenerate;
            got.area_deg = res.area_degenerate;
            faces.check_face(got);
        end
        if ((vtx.valid && vtx.ready) || (res.valid && res.ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("[triangle_normal_tangent] ERROR");
            $finish;
        end
    end

    // result side stalls
    initial begin
        int g;
        @(negedge i_clk);
        forever begin
            g = pick_gap();
            if (g == 0) begin
                res.ready = 1;
                @(negedge i_clk);
            end else begin
                res.ready = 0;
                repeat (g) @(negedge i_clk);
            end
        end
    end

    task automatic send_vertex(logic signed [31:0] x, y, z, u, v);
        int g;
        g = pick_gap();
        if (g > 0) begin
            vtx.valid = 0;
            repeat (g) @(negedge i_clk);
        end
        vtx.valid = 1;
        vtx.pos_x = x; vtx.pos_y = y; vtx.pos_z = z;
        vtx.tex_u = u; vtx.tex_v = v;
        do @(posedge i_clk); while (!vtx.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        vtx.valid = 0;
        while (faces.faces_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_make_normals(bit value);
        i_cfg_valid = 1;
        i_cfg_make_normals = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        faces.make_normals = value;
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    function automatic logic signed [31:0] rand_coord(int kind);
        case (kind)
            0: return $urandom();
            1: return $signed($urandom_range(0, 2097151)) - 1048576;
            2: return $signed($urandom_range(0, 1023)) - 512;
            default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    task automatic random_triangle();
        logic signed [31:0] p[3][5];
        int kind, r;
        kind = $urandom_range(0, 9);
        kind = (kind < 3) ? 0 : (kind < 6) ? 1 : (kind < 9) ? 2 : 3;
        for (int i = 0; i < 3; i++)
            for (int f = 0; f < 5; f++) p[i][f] = rand_coord(kind);
        r = $urandom_range(0, 9);
        if (r == 0) for (int f = 0; f < 3; f++) p[2][f] = p[1][f];
        if (r == 1) begin
            p[2][3] = p[1][3];
            p[2][4] = p[1][4];
        end
        if (r == 2) for (int f = 0; f < 3; f++) p[2][f] = p[0][f] + 2 * (p[1][f] - p[0][f]);
        if (r == 3) begin
            p[1][3] = p[0][3];
            p[2][3] = p[0][3];
        end
        for (int i = 0; i < 3; i++) send_vertex(p[i][0], p[i][1], p[i][2], p[i][3], p[i][4]);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        steady = 1;
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(32'h10000, 0, 0, 32'h10000, 0);
        send_vertex(0, 32'h10000, 0, 0, 32'h10000);
        send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(1, 1, 1, 1, 0);
        send_vertex(2, 2, 2, 0, 1);
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(0, 0, 1, 1, 0);
        send_vertex(0, 1, 0, 32'h7fffffff, 1);
        send_vertex(-1, -1, -1, -1, -1);
        send_vertex(-1, -1, -1, -1, -1);
        send_vertex(-1, -1, -1, -1, -1);
        send_vertex(5, 0, 0, 0, 0);
        send_vertex(32'h7fff, 0, 0, 32'h7fffffff, 32'h7fffffff);
        send_vertex(0, 32'h7fffffff, 0, 32'h80000000, 32'h7fffffff);
        steady = 0;
        drain();

        write_make_normals(0);
        for (int t = 0; t < 70; t++) random_triangle();
        send_vertex(7, 8, 9, 1, 2);
        drain();
        write_make_normals(1);
        for (int t = 0; t < 120; t++) begin
            steady = (t >= 40 && t < 70);
            random_triangle();
        end
        steady = 0;
        drain();
        write_make_normals(1);
        for (int t = 0; t < 120; t++) random_triangle();
        send_vertex(3, 2, 1, 5, 4);
        send_vertex(1, 2, 3, 4, 5);
        drain();
        write_make_normals(0);
        for (int t = 0; t < 50; t++) random_triangle();
        drain();
        write_make_normals(1);
        for (int t = 0; t < 100; t++) random_triangle();
        drain();

        if (faces.errors == 0) begin
            $display("[triangle_normal_tangent] OK");
        end else begin
            $display("[triangle_normal_tangent] ERROR");
        end
        $finish;
    end
endmodule
